// ===== hdl/fvcc_pkg.sv =====
// shared types, widths and constant tables of the flow vector color coder
package fvcc_pkg;

   localparam int CORDIC_W = 27;
   localparam int SQRT_ITERS = 16;
   localparam int WHEEL_SIZE = 55;

   typedef struct packed {
      logic signed [CORDIC_W-1:0] x;
      logic signed [CORDIC_W-1:0] y;
      logic [31:0] phase;
      logic y_zero;
      logic x_neg;
   } cordic_type;

   typedef struct packed {
      logic [31:0] rem;
      logic [31:0] root;
      logic in_unit;
   } sqrt_type;

   function automatic logic [31:0] atan_at(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0: v = 32'd536870912;
         5'd1: v = 32'd316933406;
         5'd2: v = 32'd167458907;
         5'd3: v = 32'd85004756;
         5'd4: v = 32'd42667331;
         5'd5: v = 32'd21354465;
         5'd6: v = 32'd10679838;
         5'd7: v = 32'd5340245;
         5'd8: v = 32'd2670163;
         5'd9: v = 32'd1335087;
         5'd10: v = 32'd667544;
         5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;
         5'd13: v = 32'd83443;
         5'd14: v = 32'd41722;
         5'd15: v = 32'd20861;
         5'd16: v = 32'd10430;
         5'd17: v = 32'd5215;
         5'd18: v = 32'd2608;
         5'd19: v = 32'd1304;
         5'd20: v = 32'd652;
         5'd21: v = 32'd326;
         5'd22: v = 32'd163;
         5'd23: v = 32'd81;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

   // color wheel entry as {red, green, blue}
   function automatic logic [23:0] wheel_at(input logic [5:0] idx);
      logic [23:0] v;
      case (idx)
         6'd0: v = {8'd255, 8'd0, 8'd0};
         6'd1: v = {8'd255, 8'd17, 8'd0};
         6'd2: v = {8'd255, 8'd34, 8'd0};
         6'd3: v = {8'd255, 8'd51, 8'd0};
         6'd4: v = {8'd255, 8'd68, 8'd0};
         6'd5: v = {8'd255, 8'd85, 8'd0};
         6'd6: v = {8'd255, 8'd102, 8'd0};
         6'd7: v = {8'd255, 8'd119, 8'd0};
         6'd8: v = {8'd255, 8'd136, 8'd0};
         6'd9: v = {8'd255, 8'd153, 8'd0};
         6'd10: v = {8'd255, 8'd170, 8'd0};
         6'd11: v = {8'd255, 8'd187, 8'd0};
         6'd12: v = {8'd255, 8'd204, 8'd0};
         6'd13: v = {8'd255, 8'd221, 8'd0};
         6'd14: v = {8'd255, 8'd238, 8'd0};
         6'd15: v = {8'd255, 8'd255, 8'd0};
         6'd16: v = {8'd213, 8'd255, 8'd0};
         6'd17: v = {8'd170, 8'd255, 8'd0};
         6'd18: v = {8'd128, 8'd255, 8'd0};
         6'd19: v = {8'd85, 8'd255, 8'd0};
         6'd20: v = {8'd43, 8'd255, 8'd0};
         6'd21: v = {8'd0, 8'd255, 8'd0};
         6'd22: v = {8'd0, 8'd255, 8'd63};
         6'd23: v = {8'd0, 8'd255, 8'd127};
         6'd24: v = {8'd0, 8'd255, 8'd191};
         6'd25: v = {8'd0, 8'd255, 8'd255};
         6'd26: v = {8'd0, 8'd232, 8'd255};
         6'd27: v = {8'd0, 8'd209, 8'd255};
         6'd28: v = {8'd0, 8'd186, 8'd255};
         6'd29: v = {8'd0, 8'd163, 8'd255};
         6'd30: v = {8'd0, 8'd140, 8'd255};
         6'd31: v = {8'd0, 8'd116, 8'd255};
         6'd32: v = {8'd0, 8'd93, 8'd255};
         6'd33: v = {8'd0, 8'd70, 8'd255};
         6'd34: v = {8'd0, 8'd47, 8'd255};
         6'd35: v = {8'd0, 8'd24, 8'd255};
         6'd36: v = {8'd0, 8'd0, 8'd255};
         6'd37: v = {8'd19, 8'd0, 8'd255};
         6'd38: v = {8'd39, 8'd0, 8'd255};
         6'd39: v = {8'd58, 8'd0, 8'd255};
         6'd40: v = {8'd78, 8'd0, 8'd255};
         6'd41: v = {8'd98, 8'd0, 8'd255};
         6'd42: v = {8'd117, 8'd0, 8'd255};
         6'd43: v = {8'd137, 8'd0, 8'd255};
         6'd44: v = {8'd156, 8'd0, 8'd255};
         6'd45: v = {8'd176, 8'd0, 8'd255};
         6'd46: v = {8'd196, 8'd0, 8'd255};
         6'd47: v = {8'd215, 8'd0, 8'd255};
         6'd48: v = {8'd235, 8'd0, 8'd255};
         6'd49: v = {8'd255, 8'd0, 8'd255};
         6'd50: v = {8'd255, 8'd0, 8'd213};
         6'd51: v = {8'd255, 8'd0, 8'd170};
         6'd52: v = {8'd255, 8'd0, 8'd128};
         6'd53: v = {8'd255, 8'd0, 8'd85};
         6'd54: v = {8'd255, 8'd0, 8'd43};
         default: v = 24'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== hdl/fvcc_cordic_stage.sv =====
// one vectoring cordic rotation stage, or a plain register past the last stage
module fvcc_cordic_stage #(
   parameter int IDX = 0,
   parameter int ACTIVE = 1
) (
   input  logic                   clock,
   input  logic                   en,
   input  fvcc_pkg::cordic_type   d_in,
   output fvcc_pkg::cordic_type   d_out
);

   fvcc_pkg::cordic_type q_ff, q_in;
   logic signed [fvcc_pkg::CORDIC_W-1:0] dx, dy;
   logic [31:0] ang;

   always_comb begin
      dx = d_in.y >>> IDX;
      dy = d_in.x >>> IDX;
      ang = fvcc_pkg::atan_at(5'(IDX));
      q_in = d_in;
      if (ACTIVE != 0) begin
         if (!d_in.y[fvcc_pkg::CORDIC_W-1]) begin
            q_in.x = d_in.x + dx;
            q_in.y = d_in.y - dy;
            q_in.phase = d_in.phase + ang;
         end else begin
            q_in.x = d_in.x - dx;
            q_in.y = d_in.y + dy;
            q_in.phase = d_in.phase - ang;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff <= q_in;
      end
   end

   assign d_out = q_ff;

endmodule

// ===== hdl/fvcc_sqrt_stage.sv =====
// one digit step of the integer square root, or a plain register past the last step
module fvcc_sqrt_stage #(
   parameter int IDX = 0,
   parameter int ACTIVE = 1
) (
   input  logic                 clock,
   input  logic                 en,
   input  fvcc_pkg::sqrt_type   d_in,
   output fvcc_pkg::sqrt_type   d_out
);

   localparam logic [31:0] BIT = (ACTIVE != 0) ? (32'd1 << (30 - 2 * IDX)) : 32'd0;

   fvcc_pkg::sqrt_type q_ff, q_in;
   logic [32:0] trial;

   always_comb begin
      trial = {1'b0, d_in.root} + {1'b0, BIT};
      q_in = d_in;
      if (ACTIVE != 0) begin
         if ({1'b0, d_in.rem} >= trial) begin
            q_in.rem = d_in.rem - trial[31:0];
            q_in.root = (d_in.root >> 1) + BIT;
         end else begin
            q_in.root = d_in.root >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff <= q_in;
      end
   end

   assign d_out = q_ff;

endmodule

// ===== hdl/fvcc_color.sv =====
// four-stage color back end: segment pick, wheel blend, saturation multiply, final scale
module fvcc_color #(
   parameter int FRAC_BITS = 12
) (
   input  logic         clock,
   input  logic [3:0]   en,
   input  logic [31:0]  phase,
   input  logic         y_zero,
   input  logic         x_neg,
   input  logic [15:0]  radius,
   input  logic         in_unit,
   output logic [7:0]   red,
   output logic [7:0]   green,
   output logic [7:0]   blue
);

   localparam int SH = FRAC_BITS + 8;
   localparam logic [33:0] ROUND_ADD = (34'd1 << SH) - 34'd1;

   // stage a: segment index and blend fraction
   logic [31:0] ph_eff;
   logic [37:0] prod;
   logic [5:0]  k0_ff, k0_in;
   logic [7:0]  f_ff, f_in;
   logic [15:0] ra_ff;
   logic        ia_ff;

   always_comb begin
      ph_eff = y_zero ? (x_neg ? 32'h8000_0000 : 32'd0) : phase;
      prod = {6'd0, ph_eff} * 38'd54;
      k0_in = prod[37:32];
      f_in = prod[31:24];
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         k0_ff <= k0_in;
         f_ff <= f_in;
         ra_ff <= radius;
         ia_ff <= in_unit;
      end
   end

   // stage b: wheel lookup and blend
   logic [5:0]  k1;
   logic [23:0] c0, c1;
   logic [8:0]  w0;
   logic [15:0] bl_in [3];
   logic [15:0] bl_ff [3];
   logic [15:0] rb_ff;
   logic        ib_ff;

   always_comb begin
      k1 = (k0_ff == 6'(fvcc_pkg::WHEEL_SIZE - 1)) ? 6'd0 : k0_ff + 6'd1;
      c0 = fvcc_pkg::wheel_at(k0_ff);
      c1 = fvcc_pkg::wheel_at(k1);
      w0 = 9'd256 - {1'b0, f_ff};
      for (int c = 0; c < 3; c++) begin
         bl_in[c] = 16'(({8'd0, w0} * {9'd0, c0[23-8*c -: 8]})
                      + ({9'd0, f_ff} * {9'd0, c1[23-8*c -: 8]}));
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         bl_ff <= bl_in;
         rb_ff <= ra_ff;
         ib_ff <= ia_ff;
      end
   end

   // stage c: radius times distance from white, and the outside scale
   logic [31:0] num_in [3];
   logic [31:0] num_ff [3];
   logic [7:0]  out_in [3];
   logic [7:0]  out_ff [3];
   logic [17:0] x3;
   logic        ic_ff;

   always_comb begin
      x3 = 18'd0;
      for (int c = 0; c < 3; c++) begin
         num_in[c] = {16'd0, rb_ff} * {16'd0, 16'd65280 - bl_ff[c]};
         x3 = {2'd0, bl_ff[c]} * 18'd3;
         out_in[c] = x3[17:10];
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         num_ff <= num_in;
         out_ff <= out_in;
         ic_ff <= ib_ff;
      end
   end

   // stage d: rounded-up scale and subtract from full white, or pass on the outside value
   logic [33:0] dsum;
   logic [33:0] dq;
   logic [7:0]  ch_in [3];
   logic [7:0]  ch_ff [3];

   always_comb begin
      dsum = 34'd0;
      dq = 34'd0;
      for (int c = 0; c < 3; c++) begin
         dsum = {2'd0, num_ff[c]} + ROUND_ADD;
         dq = dsum >> SH;
         if (ic_ff) begin
            ch_in[c] = (dq >= 34'd255) ? 8'd0 : 8'd255 - dq[7:0];
         end else begin
            ch_in[c] = out_ff[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         ch_ff <= ch_in;
      end
   end

   assign red = ch_ff[0];
   assign green = ch_ff[1];
   assign blue = ch_ff[2];

endmodule

// ===== hdl/flow_vector_color_coder_core.sv =====
// flow vector to color wheel pixel coder, fully pipelined
// a beat passes the entry stage, the middle stages and the color back end in turn
// throughput: one beat per cycle while rsp_tready holds; the cordic and square-root stage chains set the depth
// each stage holds its beat under backpressure while empty stages upstream keep filling
// reset clears all valid bits; payload registers are not reset
module flow_vector_color_coder_core #(
   parameter int FRAC_BITS = 12,
   parameter int CORDIC_STAGES = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // flow_x [15:0], flow_y [31:16]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [23:0]  rsp_tdata    // red [7:0], green [15:8], blue [23:16]
);

   // middle stages run both the cordic and the square root side by side
   localparam int MID = (CORDIC_STAGES > fvcc_pkg::SQRT_ITERS) ? CORDIC_STAGES
                                                               : fvcc_pkg::SQRT_ITERS;
   localparam int TOTAL = MID + 5;
   localparam logic [40:0] UNIT_SQ = 41'd1 << (2 * FRAC_BITS);

   // per-stage valid bits and enables; an empty stage always takes a new beat
   logic [TOTAL-1:0] vld_ff, vld_in;
   logic [TOTAL:0]   en;

   always_comb begin
      en[TOTAL] = rsp_tready;
      for (int k = TOTAL - 1; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
      for (int k = 0; k < TOTAL; k++) begin
         if (k == 0) begin
            vld_in[k] = en[k] ? req_tvalid : vld_ff[k];
         end else begin
            vld_in[k] = en[k] ? vld_ff[k-1] : vld_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_tready = en[0];
   assign rsp_tvalid = vld_ff[TOTAL-1];

   // entry stage: squares for the radius, half-turn fold for the cordic
   logic signed [15:0] fx, fy;
   logic signed [31:0] xx, yy;
   logic [31:0] sq;
   logic signed [fvcc_pkg::CORDIC_W-1:0] sx, sy;
   fvcc_pkg::cordic_type cor_in0, cor_ff0;
   fvcc_pkg::sqrt_type   sqr_in0, sqr_ff0;

   always_comb begin
      fx = req_tdata[15:0];
      fy = req_tdata[31:16];
      xx = fx * fx;
      yy = fy * fy;
      sq = xx + yy;
      sx = {{(fvcc_pkg::CORDIC_W-24){fx[15]}}, fx, 8'd0};
      sy = {{(fvcc_pkg::CORDIC_W-24){fy[15]}}, fy, 8'd0};
      cor_in0.y_zero = (fy == 16'sd0);
      cor_in0.x_neg = fx[15];
      if (fx[15]) begin
         cor_in0.x = -sx;
         cor_in0.y = -sy;
         cor_in0.phase = 32'h8000_0000;
      end else begin
         cor_in0.x = sx;
         cor_in0.y = sy;
         cor_in0.phase = 32'd0;
      end
      sqr_in0.rem = sq;
      sqr_in0.root = 32'd0;
      sqr_in0.in_unit = ({9'd0, sq} <= UNIT_SQ);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         cor_ff0 <= cor_in0;
         sqr_ff0 <= sqr_in0;
      end
   end

   // middle stages
   fvcc_pkg::cordic_type cor [MID+1];
   fvcc_pkg::sqrt_type   sqr [MID+1];

   assign cor[0] = cor_ff0;
   assign sqr[0] = sqr_ff0;

   for (genvar g = 0; g < MID; g++) begin : g_mid
      fvcc_cordic_stage #(
         .IDX    (g),
         .ACTIVE ((g < CORDIC_STAGES) ? 1 : 0)
      ) u_cordic (
         .clock (clock),
         .en    (en[g+1]),
         .d_in  (cor[g]),
         .d_out (cor[g+1])
      );
      fvcc_sqrt_stage #(
         .IDX    (g),
         .ACTIVE ((g < fvcc_pkg::SQRT_ITERS) ? 1 : 0)
      ) u_sqrt (
         .clock (clock),
         .en    (en[g+1]),
         .d_in  (sqr[g]),
         .d_out (sqr[g+1])
      );
   end

   // color back end, last four stages
   logic [7:0] red, green, blue;

   fvcc_color #(
      .FRAC_BITS (FRAC_BITS)
   ) u_color (
      .clock   (clock),
      .en      (en[TOTAL-1:TOTAL-4]),
      .phase   (cor[MID].phase),
      .y_zero  (cor[MID].y_zero),
      .x_neg   (cor[MID].x_neg),
      .radius  (sqr[MID].root[15:0]),
      .in_unit (sqr[MID].in_unit),
      .red     (red),
      .green   (green),
      .blue    (blue)
   );

   assign rsp_tdata = {blue, green, red};

endmodule

// ===== hdl/fvcc_checker.sv =====
// port-level checks of the color coder, bound to the top level
module fvcc_checker #(
   parameter int FRAC_BITS = 12,
   parameter int CORDIC_STAGES = 16
) (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [31:0]  req_tdata,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [23:0]  rsp_tdata
);

   localparam int DEPTH = ((CORDIC_STAGES > 16) ? CORDIC_STAGES : 16) + 5;

   logic [7:0] inflight_ff, inflight_in;
   logic acc_in, acc_out;

   assign acc_in = req_tvalid && req_tready;
   assign acc_out = rsp_tvalid && rsp_tready;

   always_comb begin
      inflight_in = inflight_ff + {7'd0, acc_in} - {7'd0, acc_out};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> inflight_ff != 8'd0)
      else $error("result with no item in flight");

   a_bound: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= 8'(DEPTH))
      else $error("more items in flight than pipeline stages");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled while output stage empty");

endmodule

bind flow_vector_color_coder_core fvcc_checker #(
   .FRAC_BITS     (FRAC_BITS),
   .CORDIC_STAGES (CORDIC_STAGES)
) u_fvcc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== sim/tb_flow_vector_color_coder_core.sv =====
// self-checking testbench of the flow vector color coder core
module tb_flow_vector_color_coder_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC_BITS = 12;
   localparam int CORDIC_STAGES = 16;
   localparam int LATENCY = (CORDIC_STAGES > 16 ? CORDIC_STAGES : 16) + 5;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [31:0] req_tdata = '0;   // flow_x [15:0], flow_y [31:16]
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // red [7:0], green [15:8], blue [23:16]

   pixel_type pixel_queue[$];
   int mismatches = 0;
   int beats_sent = 0;
   int beats_seen = 0;
   int cycles = 0;
   int hold_cycles = 0;   // receiver hold-off, counted down by the receiver

   flow_vector_color_coder_core #(
      .FRAC_BITS(FRAC_BITS),
      .CORDIC_STAGES(CORDIC_STAGES)
   ) dut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   // arctangent per cordic stage, one full turn = 2^32
   function automatic logic [31:0] atan_step(input int i);
      logic [31:0] t[24];
      t = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
            32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
            32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
            32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
            32'd81};
      return t[i];
   endfunction

   // run lengths of the wheel: red-yellow 15, yellow-green 6, green-cyan 4,
   // cyan-blue 11, blue-magenta 13, magenta-red 6
   function automatic logic [23:0] wheel_color(input int k);
      int r, g, b;
      if (k < 15) begin
         r = 255; g = 255 * k / 15; b = 0;
      end else if (k < 21) begin
         r = 255 - (255 * (k - 15)) / 6; g = 255; b = 0;
      end else if (k < 25) begin
         r = 0; g = 255; b = 255 * (k - 21) / 4;
      end else if (k < 36) begin
         r = 0; g = 255 - (255 * (k - 25)) / 11; b = 255;
      end else if (k < 49) begin
         r = 255 * (k - 36) / 13; g = 0; b = 255;
      end else begin
         r = 255; g = 0; b = 255 - (255 * (k - 49)) / 6;
      end
      return {8'(r), 8'(g), 8'(b)};
   endfunction

   // phase of a vector as a turn fraction
   function automatic logic [31:0] flow_phase(input longint x, input longint y);
      logic [31:0] ph;
      longint dx, dy;
      ph = 0;
      if (y == 0) return (x < 0) ? 32'h8000_0000 : 32'h0;
      x = x * 256;
      y = y * 256;
      if (x < 0) begin
         x = -x; y = -y; ph = 32'h8000_0000;
      end
      for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; ph += atan_step(i);
         end else begin
            x -= dx; y += dy; ph -= atan_step(i);
         end
      end
      return ph;
   endfunction

   function automatic pixel_type color_of_flow(input logic signed [15:0] fx,
                                               input logic signed [15:0] fy);
      longint unsigned sq, rt, p, blend, num, d, v;
      longint x, y;
      int k0, k1, f;
      logic [23:0] c0, c1;
      logic in_unit;
      pixel_type px;
      x = fx;
      y = fy;
      sq = x * x + y * y;
      in_unit = sq <= (64'd1 << (2 * FRAC_BITS));
      rt = 0;
      while ((rt + 1) * (rt + 1) <= sq) rt++;
      if (rt > 0) begin end
      p = longint'(flow_phase(x, y)) * 54;
      k0 = int'(p >> 32);
      f = int'((p >> 24) & 8'hFF);
      if (k0 > 54) k0 = 54;
      k1 = (k0 + 1) % 55;
      c0 = wheel_color(k0);
      c1 = wheel_color(k1);
      for (int c = 0; c < 3; c++) begin
         blend = (256 - f) * c0[8*(2-c) +: 8] + f * c1[8*(2-c) +: 8];
         if (in_unit) begin
            num = rt * (65280 - blend);
            d = (num + (64'd1 << (FRAC_BITS + 8)) - 1) >> (FRAC_BITS + 8);
            v = (d >= 255) ? 0 : 255 - d;
         end else begin
            v = (3 * blend) >> 10;
         end
         if (v > 255) v = 255;
         px[8*c +: 8] = v[7:0];
      end
      return px;
   endfunction

   // sends one vector after a random gap and records its expected pixel
   task automatic send_flow(input logic [15:0] fx, input logic [15:0] fy);
      int gap;
      gap = $urandom_range(0, 4);
      if (gap > 0 && req_tvalid) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end else begin
         repeat (gap) @(negedge clock);
      end
      req_tdata <= {fy, fx};
      req_tvalid <= 1'b1;
      pixel_queue.push_back(color_of_flow(fx, fy));
      do @(posedge clock); while (!req_tready);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic end_burst();
      req_tvalid <= 1'b0;
      @(negedge clock);
   endtask

   // receiver: random stall per beat, long hold-off on request
   initial begin
      int stall;
      @(negedge clock);
      forever begin
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_cycles--;
            @(negedge clock);
         end else begin
            stall = $urandom_range(0, 4);
            if ($urandom_range(0, 3) == 0) stall = 0;
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(negedge clock);
            end
            rsp_tready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // result checker, sampled at the rising edge
   always @(posedge clock) begin
      pixel_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         beats_seen++;
         if (pixel_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected pixel beat %h", got);
         end else begin
            want = pixel_queue.pop_front();
            if (got.red !== want.red || got.green !== want.green ||
                got.blue !== want.blue) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("pixel %0d: expected r%0d g%0d b%0d, got r%0d g%0d b%0d",
                           beats_seen, want.red, want.green, want.blue,
                           got.red, got.green, got.blue);
            end
         end
      end
   end

   // watchdog on the cycle count
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("status: fail");
         $finish;
      end
   end

   // axes, corners, zero and unit circle boundary
   task automatic test_directed();
      logic [15:0] vals[8];
      vals = '{16'h0000, 16'h0001, 16'hFFFF, 16'h1000, 16'hF000,
               16'h7FFF, 16'h8000, 16'h0B50};
      send_flow(16'h0000, 16'h0000);
      for (int i = 1; i < 8; i++) begin
         send_flow(vals[i], 16'h0000);
         send_flow(16'h0000, vals[i]);
      end
      send_flow(16'h0B50, 16'h0B50);
      send_flow(16'h0B51, 16'hF4AF);
      send_flow(16'h1000, 16'hFFFF);
      send_flow(16'h8000, 16'h8000);
      send_flow(16'h7FFF, 16'h7FFF);
      send_flow(16'hF000, 16'h0001);
      end_burst();
   endtask

   // mostly vectors near unit radius, some over the full range
   task automatic test_random(input int count);
      logic [15:0] fx, fy;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(0, 3))
            0: begin
               fx = 16'($urandom); fy = 16'($urandom);
            end
            1: begin
               fx = 16'($signed($urandom_range(0, 8192)) - 4096);
               fy = 16'($signed($urandom_range(0, 8192)) - 4096);
            end
            2: begin
               fx = 16'($signed($urandom_range(0, 512)) - 256);
               fy = 16'($signed($urandom_range(0, 512)) - 256);
            end
            default: begin
               fx = 16'($signed($urandom_range(0, 16384)) - 8192);
               fy = 16'($signed($urandom_range(0, 16384)) - 8192);
            end
         endcase
         send_flow(fx, fy);
      end
      end_burst();
   endtask

   // receiver stops for a long stretch while the sender keeps offering
   task automatic test_backpressure();
      hold_cycles = 4 * LATENCY + 20;
      test_random(3 * LATENCY);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(1200);
      test_backpressure();
      test_random(460);
      while (pixel_queue.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
      $display("sent %0d flow vectors (axes, corners, unit radius, random), checked %0d pixels",
               beats_sent, beats_seen);
      $display("mismatches: %0d, including a long output stall", mismatches);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/fvcc_pkg.sv
hdl/fvcc_cordic_stage.sv
hdl/fvcc_sqrt_stage.sv
hdl/fvcc_color.sv
hdl/flow_vector_color_coder_core.sv
hdl/fvcc_checker.sv
sim/tb_flow_vector_color_coder_core.sv
